### design/chpc_pkg.sv
// ----------------------------------------------------------------------------
// chpc_pkg
// Shared types and constants of the crystal hit polynomial calibrator.
// ----------------------------------------------------------------------------
package chpc_pkg;

	// Request kinds on the input channel.
	typedef enum logic {
		REQ_HIT  = 1'b0,
		REQ_COEF = 1'b1
	} req_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_NUM_CRYSTALS = 1'b0,
		REG_NUM_TERMS    = 1'b1
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_DONE
	} state_t;

	// Digitizer error masks.
	localparam logic [15:0] ERR_ANY  = 16'h061e;
	localparam logic [15:0] ERR_QPID = 16'h1980 | ERR_ANY;
	localparam logic [15:0] ERR_EN   = 16'h0020 | ERR_ANY;

	localparam int NCRY_W   = 13;
	localparam int NTERM_W  = 3;
	// Only powers 0 to 3 can ever be written (two-bit term index).
	localparam int WR_TERMS = 4;
	localparam int POW_W    = 2;

	localparam int X_W    = 17;  // signed raw sample
	localparam int X2_W   = 34;
	localparam int PWR_W  = 51;  // signed raw cubed
	localparam int LO_W   = 26;  // low slice of the power operand
	localparam int HI_W   = PWR_W - LO_W;
	localparam int COEF_W = 32;
	localparam int CAL_W  = 64;
	localparam int ACC_W  = 84;

	typedef logic signed [ACC_W-1:0] acc_t;

	// Per-lane control from the sequencer.
	typedef struct packed {
		logic             load;    // new hit: take raw sample, clear sum
		logic [POW_W-1:0] pw;      // power that goes with the coefficient read
		logic             acc_en;  // add the registered products
	} lane_ctrl_t;

endpackage

### design/chpc_coef_ram.sv
// ----------------------------------------------------------------------------
// chpc_coef_ram
// Single-port coefficient store with registered read data.
// ----------------------------------------------------------------------------
module chpc_coef_ram import chpc_pkg::*; #(
	parameter int DEPTH  = 16384,
	parameter int ADDR_W = 14
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [COEF_W-1:0] wdata,
	output logic [COEF_W-1:0] rdata
);

	logic [COEF_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

### design/chpc_lane.sv
// ----------------------------------------------------------------------------
// chpc_lane
// One calibration channel: raw powers, coefficient product and exact sum,
// saturated to signed Q47.16.
// ----------------------------------------------------------------------------
module chpc_lane import chpc_pkg::*; (
	input  logic                    clk,
	input  lane_ctrl_t              ctrl,
	input  logic signed [X_W-1:0]   x_in,
	input  logic [COEF_W-1:0]       coef,
	output logic signed [CAL_W-1:0] cal
);

	logic signed [X_W-1:0]         x_q;
	logic signed [X2_W-1:0]        x2_q;
	logic signed [PWR_W-1:0]       x3_q;
	logic signed [PWR_W-1:0]       pwr;
	logic signed [LO_W:0]          pwr_lo;
	logic signed [HI_W-1:0]        pwr_hi;
	logic signed [COEF_W+LO_W:0]   prod_lo_s2;
	logic signed [COEF_W+HI_W-1:0] prod_hi_s2;
	acc_t                          acc_q;
	logic                          fits;

	// The square and then the cube are registered from the loaded sample and settle
	// before the coefficients that need them come out of the store.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q <= x_in;
		end
		x2_q <= x_q * x_q;
		x3_q <= x2_q * x_q;
	end

	always_comb begin
		case (ctrl.pw)
			2'd0:    pwr = PWR_W'(1);
			2'd1:    pwr = PWR_W'(x_q);
			2'd2:    pwr = PWR_W'(x2_q);
			default: pwr = x3_q;
		endcase
		pwr_lo = $signed({1'b0, pwr[LO_W-1:0]});
		pwr_hi = pwr[PWR_W-1:LO_W];
	end

	always_ff @(posedge clk) begin
		prod_lo_s2 <= $signed(coef) * pwr_lo;
		prod_hi_s2 <= $signed(coef) * pwr_hi;
		if (ctrl.load) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + (acc_t'(prod_hi_s2) <<< LO_W) + acc_t'(prod_lo_s2);
		end
	end

	assign fits = (&acc_q[ACC_W-1:CAL_W-1]) || !(|acc_q[ACC_W-1:CAL_W-1]);

	always_comb begin
		if (fits) begin
			cal = acc_q[CAL_W-1:0];
		end else if (acc_q[ACC_W-1]) begin
			cal = {1'b1, {(CAL_W-1){1'b0}}};
		end else begin
			cal = {1'b0, {(CAL_W-1){1'b1}}};
		end
	end

endmodule

### design/crystal_hit_poly_calibrator_top.sv
// ----------------------------------------------------------------------------
// crystal_hit_poly_calibrator_top
// Per-crystal polynomial calibration of energy, fast and slow hit components.
// ----------------------------------------------------------------------------
// Each request is either a coefficient write or a hit. A coefficient write
// stores one signed Q16.16 word for a crystal and power in the coefficient
// RAM and returns nothing. A hit returns one result: for each channel not
// flagged by its digitizer error mask, the sum of coefficient p times raw
// to the power p over the configured number of terms (with a single term,
// coefficient times raw), exact and then saturated to signed Q47.16. A hit
// whose crystal id is zero, above num_crystals or above MAX_CRYSTALS returns
// all three channels invalid with zero values. On a hit on a valid crystal,
// the single-port coefficient RAM delivers one coefficient per cycle, and
// the multiply and accumulate stages behind it drain before the result is
// handed over. The three channels run side by side in their own lanes and
// share each coefficient read. The finished result sits in an output
// register, so the next request is taken while it waits to be collected.
// Coefficients must be written before any hit reads them; the RAM is not
// cleared after reset. Configuration is on the APB port: num_crystals at
// address 0, num_terms at address 4.
// ----------------------------------------------------------------------------
module crystal_hit_poly_calibrator_top import chpc_pkg::*; #(
	parameter int MAX_CRYSTALS = 4096,
	parameter int MAX_TERMS    = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// request channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    req_type,
	input  logic [15:0]             crystal_id,
	input  logic [15:0]             raw_energy,
	input  logic signed [15:0]      raw_fast,
	input  logic signed [15:0]      raw_slow,
	input  logic [15:0]             error_bits,
	input  logic [63:0]             hit_time,
	input  logic [15:0]             over_threshold,
	input  logic [1:0]              term_index,
	input  logic signed [31:0]      coef_value,
	// result channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [15:0]             out_crystal_id,
	output logic signed [63:0]      energy_cal,
	output logic signed [63:0]      fast_cal,
	output logic signed [63:0]      slow_cal,
	output logic                    energy_ok,
	output logic                    fast_ok,
	output logic                    slow_ok,
	output logic [63:0]             out_time,
	output logic [15:0]             out_over_threshold,
	// configuration port
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	// Crystal id, term p lives at (id - 1) * MAX_TERMS + p.
	localparam int DEPTH    = MAX_CRYSTALS * MAX_TERMS;
	localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// Terms beyond the writable powers can never hold a written value, so
	// the sequencer does not read them.
	localparam int TERM_CAP = (MAX_TERMS < WR_TERMS) ? MAX_TERMS : WR_TERMS;

	// Configuration registers.
	logic [NCRY_W-1:0]  num_crystals_q;
	logic [NTERM_W-1:0] num_terms_q;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	// Sequencer.
	state_t             state_q, state_d;
	logic [NTERM_W-1:0] term_q;
	logic [NTERM_W-1:0] terms_q;
	logic [NTERM_W-1:0] terms_eff;
	logic [ADDR_W-1:0]  base_q;
	logic               rd_v_s1;
	logic [POW_W-1:0]   pw_s1;
	logic               mul_v_s2;
	logic               accept;
	logic               is_hit;
	logic               id_ok;
	logic               wr_ok;
	logic               out_load;
	logic [31:0]        addr_full;

	// Coefficient RAM port.
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_addr;
	logic [COEF_W-1:0]  mem_rdata;

	// Hit payload held while the hit is worked on.
	logic [15:0]        id_q;
	logic [63:0]        time_q;
	logic [15:0]        tot_q;
	logic [2:0]         ok_q;

	// Lanes.
	lane_ctrl_t         lane_ctrl;
	logic signed [CAL_W-1:0] cal_en, cal_fa, cal_sl;

	// Result register.
	logic               out_valid_q;

	//------------------------------------------------------------------------
	// Configuration port. Writes complete in the access phase; reads return
	// the stored value.
	//------------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_crystals_q <= '0;
			num_terms_q    <= NTERM_W'(1);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_NUM_CRYSTALS: num_crystals_q <= pwdata[NCRY_W-1:0];
				REG_NUM_TERMS:    num_terms_q    <= pwdata[NTERM_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_NUM_CRYSTALS: prdata = {{(32-NCRY_W){1'b0}}, num_crystals_q};
			REG_NUM_TERMS:    prdata = {{(32-NTERM_W){1'b0}}, num_terms_q};
			default:          prdata = '0;
		endcase
	end

	// A register value of zero means one term; anything above the cap is
	// clamped to it.
	always_comb begin
		if (num_terms_q == '0) begin
			terms_eff = NTERM_W'(1);
		end else if (32'(num_terms_q) > 32'(TERM_CAP)) begin
			terms_eff = NTERM_W'(TERM_CAP);
		end else begin
			terms_eff = num_terms_q;
		end
	end

	//------------------------------------------------------------------------
	// Request decode. A new request is taken when the sequencer is idle, or
	// in the same cycle in which the finished result moves to the output
	// register.
	//------------------------------------------------------------------------
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_IDLE) || out_load;
	assign accept   = in_valid && in_ready;
	assign is_hit   = (req_t'(req_type) == REQ_HIT);

	// The num_crystals register may exceed the store; both limits apply.
	assign id_ok = (crystal_id != '0) && (32'(crystal_id) <= 32'(num_crystals_q))
		&& (32'(crystal_id) <= 32'(MAX_CRYSTALS));
	// Coefficient writes check only the store bounds, not num_crystals.
	assign wr_ok = (crystal_id != '0) && (32'(crystal_id) <= 32'(MAX_CRYSTALS))
		&& (32'(term_index) < 32'(MAX_TERMS));

	assign addr_full = (32'(crystal_id) - 32'd1) * 32'(MAX_TERMS);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: ;
			ST_READ: begin
				if (term_q == terms_q - NTERM_W'(1)) begin
					state_d = ST_WAIT;
				end
			end
			// The last product is summed at the edge that leaves this state.
			ST_WAIT: begin
				if (mul_v_s2 && !rd_v_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (accept && is_hit) begin
			state_d = id_ok ? ST_READ : ST_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			term_q      <= '0;
			rd_v_s1     <= 1'b0;
			mul_v_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_v_s1  <= (state_q == ST_READ);
			mul_v_s2 <= rd_v_s1;
			if (accept && is_hit) begin
				term_q <= '0;
			end else if (state_q == ST_READ) begin
				term_q <= term_q + NTERM_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hit payload and per-term power code.
	always_ff @(posedge clk) begin
		if (accept && is_hit) begin
			id_q    <= crystal_id;
			time_q  <= hit_time;
			tot_q   <= over_threshold;
			terms_q <= terms_eff;
			base_q  <= addr_full[ADDR_W-1:0];
			ok_q[0] <= id_ok && ((error_bits & ERR_EN) == '0);
			ok_q[1] <= id_ok && ((error_bits & ERR_QPID) == '0);
			ok_q[2] <= id_ok && ((error_bits & ERR_QPID) == '0);
		end
		// A single term is a pure gain: the coefficient scales raw itself.
		pw_s1 <= (terms_q == NTERM_W'(1)) ? POW_W'(1) : term_q[POW_W-1:0];
	end

	//------------------------------------------------------------------------
	// Coefficient RAM. Writes use the port in the request cycle; reads use
	// it while the sequencer walks the terms of a hit.
	//------------------------------------------------------------------------
	assign mem_we = accept && !is_hit && wr_ok;

	always_comb begin
		if (state_q == ST_READ) begin
			mem_addr = base_q + ADDR_W'(term_q);
		end else begin
			mem_addr = ADDR_W'(addr_full + 32'(term_index));
		end
	end

	chpc_coef_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_coef_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (coef_value),
		.rdata (mem_rdata)
	);

	//------------------------------------------------------------------------
	// Channel lanes. All three see every coefficient read.
	//------------------------------------------------------------------------
	assign lane_ctrl.load   = accept && is_hit;
	assign lane_ctrl.pw     = pw_s1;
	assign lane_ctrl.acc_en = mul_v_s2;

	chpc_lane u_lane_energy (
		.clk  (clk),
		.ctrl (lane_ctrl),
		.x_in ($signed({1'b0, raw_energy})),
		.coef (mem_rdata),
		.cal  (cal_en)
	);

	chpc_lane u_lane_fast (
		.clk  (clk),
		.ctrl (lane_ctrl),
		.x_in ($signed({raw_fast[15], raw_fast})),
		.coef (mem_rdata),
		.cal  (cal_fa)
	);

	chpc_lane u_lane_slow (
		.clk  (clk),
		.ctrl (lane_ctrl),
		.x_in ($signed({raw_slow[15], raw_slow})),
		.coef (mem_rdata),
		.cal  (cal_sl)
	);

	//------------------------------------------------------------------------
	// Result register. An invalid channel reports a value of zero.
	//------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_crystal_id     <= id_q;
			energy_cal         <= ok_q[0] ? cal_en : '0;
			fast_cal           <= ok_q[1] ? cal_fa : '0;
			slow_cal           <= ok_q[2] ? cal_sl : '0;
			energy_ok          <= ok_q[0];
			fast_ok            <= ok_q[1];
			slow_ok            <= ok_q[2];
			out_time           <= time_q;
			out_over_threshold <= tot_q;
		end
	end

	assign out_valid = out_valid_q;

	//------------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------------
	// The RAM port is only written when no term reads are under way.
	a_write_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE || state_q == ST_DONE))
		else $error("coefficient write collides with term reads");

	// Read data is flagged valid only as a registered copy of the read state.
	a_read_origin: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> $past(state_q == ST_READ))
		else $error("read data valid without a read");

	// The term walk never passes the number of terms latched for the hit.
	a_term_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (term_q < terms_q))
		else $error("term counter beyond term count");

	// A result is handed over only once the multiply pipeline is empty.
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (!rd_v_s1 && !mul_v_s2))
		else $error("result taken before the sum is complete");

endmodule

### sim/crystal_hit_poly_calibrator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crystal_hit_poly_calibrator_top_tb
// Self-checking bench for the crystal hit polynomial calibrator.
// ----------------------------------------------------------------------------
// Coefficient writes and hits are pushed through the request channel while a
// scoreboard keeps its own copy of the coefficient RAM and the two settings.
// The scoreboard evaluates the calibration polynomial exactly and saturates
// it to Q47.16. Each collected result is compared field by field with the
// oldest prediction. A directed opening is followed by random traffic under
// several settings. Both channels stall at random.
// ----------------------------------------------------------------------------
module crystal_hit_poly_calibrator_top_tb import chpc_pkg::*;;

	localparam int MAX_CRY     = 4096;
	localparam int TERM_SLOTS  = 4;
	localparam int SETTLE      = 16;    // cycles after the last result before a register write
	localparam int STALL_LIMIT = 2000;  // cycles with nothing moving before giving up
	localparam int PHASE_ITEMS = 240;

	// Energy is lost on the shared stage flags plus its own stage; the pulse
	// shape components are lost on the shared flags plus the shape stages.
	localparam logic [15:0] ENERGY_ERR_MASK = 16'h063e;
	localparam logic [15:0] SHAPE_ERR_MASK  = 16'h1f9e;

	localparam logic signed [95:0] SAT_HI = 96'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [95:0] SAT_LO = ~SAT_HI;

	typedef struct packed {
		req_t               kind;
		logic [15:0]        crystal;
		logic [15:0]        energy;
		logic signed [15:0] fast;
		logic signed [15:0] slow;
		logic [15:0]        errors;
		logic [63:0]        stamp;
		logic [15:0]        tot;
		logic [1:0]         power;
		logic signed [31:0] coef;
	} cal_request_t;

	typedef struct packed {
		logic [15:0]        crystal;
		logic signed [63:0] energy;
		logic signed [63:0] fast;
		logic signed [63:0] slow;
		logic               energy_ok;
		logic               fast_ok;
		logic               slow_ok;
		logic [63:0]        stamp;
		logic [15:0]        tot;
	} cal_result_t;

	// ------------------------------------------------------------------------
	// Scoreboard: mirrors the coefficient RAM and the settings, predicts one
	// result per hit and checks results in order.
	// ------------------------------------------------------------------------
	class cal_scoreboard;
		logic [31:0]  coef_mem [MAX_CRY*TERM_SLOTS];
		int unsigned  crystal_limit;
		int unsigned  term_count;
		cal_result_t  expected_q[$];
		int unsigned  failures, hits_seen, in_range_hits, writes_seen, results_seen;
		int unsigned  saturations;

		function new();
			crystal_limit = 0;
			term_count    = 1;
		endfunction

		function void set_config(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_NUM_CRYSTALS: crystal_limit = value[12:0];
				REG_NUM_TERMS:    term_count    = value[2:0];
				default:          ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Exact polynomial sum, then clamped to the signed 64-bit range.
		function logic signed [63:0] calibrated_value(logic signed [16:0] raw, int base,
				int terms);
			logic signed [95:0] sum, xpow, coef, x;
			int pw, p, k;
			sum = '0;
			x   = raw;
			for (p = 0; p < terms; p++) begin
				pw   = (terms == 1) ? 1 : p;
				xpow = 96'sd1;
				for (k = 0; k < pw; k++)
					xpow = xpow * x;
				coef = $signed(coef_mem[base + p]);
				sum  = sum + coef * xpow;
			end
			if (sum > SAT_HI) begin
				saturations++;
				return SAT_HI[63:0];
			end
			if (sum < SAT_LO) begin
				saturations++;
				return SAT_LO[63:0];
			end
			return sum[63:0];
		endfunction

		function void note_request(cal_request_t r);
			cal_result_t want;
			int limit, terms, base;
			if (r.kind == REQ_COEF) begin
				writes_seen++;
				if (r.crystal >= 1 && r.crystal <= MAX_CRY)
					coef_mem[(int'(r.crystal) - 1) * TERM_SLOTS + int'(r.power)] = r.coef;
				return;
			end
			limit = (crystal_limit > MAX_CRY) ? MAX_CRY : int'(crystal_limit);
			terms = (term_count == 0) ? 1 : ((term_count > TERM_SLOTS) ? TERM_SLOTS :
				int'(term_count));
			want         = '0;
			want.crystal = r.crystal;
			want.stamp   = r.stamp;
			want.tot     = r.tot;
			if (r.crystal >= 1 && int'(r.crystal) <= limit) begin
				base           = (int'(r.crystal) - 1) * TERM_SLOTS;
				want.energy_ok = (r.errors & ENERGY_ERR_MASK) == 16'h0000;
				want.fast_ok   = (r.errors & SHAPE_ERR_MASK) == 16'h0000;
				want.slow_ok   = want.fast_ok;
				if (want.energy_ok)
					want.energy = calibrated_value({1'b0, r.energy}, base, terms);
				if (want.fast_ok) begin
					want.fast = calibrated_value(r.fast, base, terms);
					want.slow = calibrated_value(r.slow, base, terms);
				end
				in_range_hits++;
			end
			hits_seen++;
			expected_q.push_back(want);
		endfunction

		function void check_result(cal_result_t got);
			cal_result_t want;
			string diff;
			results_seen++;
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("Result %0d for crystal %0d arrived with no hit outstanding",
						results_seen, got.crystal);
				return;
			end
			want = expected_q.pop_front();
			diff = "";
			if (got.crystal !== want.crystal)     diff = {diff, " out_crystal_id"};
			if (got.energy !== want.energy)       diff = {diff, " energy_cal"};
			if (got.fast !== want.fast)           diff = {diff, " fast_cal"};
			if (got.slow !== want.slow)           diff = {diff, " slow_cal"};
			if (got.energy_ok !== want.energy_ok) diff = {diff, " energy_ok"};
			if (got.fast_ok !== want.fast_ok)     diff = {diff, " fast_ok"};
			if (got.slow_ok !== want.slow_ok)     diff = {diff, " slow_ok"};
			if (got.stamp !== want.stamp)         diff = {diff, " out_time"};
			if (got.tot !== want.tot)             diff = {diff, " out_over_threshold"};
			if (diff != "") begin
				failures++;
				if (failures <= 10) begin
					$display("Result %0d differs in%s", results_seen, diff);
					$display("  expected: id %0d E %0d/%b F %0d/%b S %0d/%b time %h tot %0d",
						want.crystal, want.energy, want.energy_ok, want.fast, want.fast_ok,
						want.slow, want.slow_ok, want.stamp, want.tot);
					$display("  actual:   id %0d E %0d/%b F %0d/%b S %0d/%b time %h tot %0d",
						got.crystal, got.energy, got.energy_ok, got.fast, got.fast_ok,
						got.slow, got.slow_ok, got.stamp, got.tot);
				end
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Signals and the device under test. Every input starts at a known value.
	// ------------------------------------------------------------------------
	logic               clk;
	logic               arst_n         = 1'b0;
	logic               in_valid       = 1'b0;
	logic               in_ready;
	logic               req_type       = 1'b0;
	logic [15:0]        crystal_id     = '0;
	logic [15:0]        raw_energy     = '0;
	logic signed [15:0] raw_fast       = '0;
	logic signed [15:0] raw_slow       = '0;
	logic [15:0]        error_bits     = '0;
	logic [63:0]        hit_time       = '0;
	logic [15:0]        over_threshold = '0;
	logic [1:0]         term_index     = '0;
	logic signed [31:0] coef_value     = '0;
	logic               out_valid;
	logic               out_ready      = 1'b0;
	logic [15:0]        out_crystal_id;
	logic signed [63:0] energy_cal, fast_cal, slow_cal;
	logic               energy_ok, fast_ok, slow_ok;
	logic [63:0]        out_time;
	logic [15:0]        out_over_threshold;
	logic               psel           = 1'b0;
	logic               penable        = 1'b0;
	logic               pwrite         = 1'b0;
	logic [2:0]         paddr          = '0;
	logic [31:0]        pwdata         = '0;
	logic [31:0]        prdata;
	logic               pready;

	crystal_hit_poly_calibrator_top #(
		.MAX_CRYSTALS(MAX_CRY),
		.MAX_TERMS   (TERM_SLOTS)
	) uut (
		.clk, .arst_n,
		.in_valid, .in_ready, .req_type, .crystal_id, .raw_energy, .raw_fast, .raw_slow,
		.error_bits, .hit_time, .over_threshold, .term_index, .coef_value,
		.out_valid, .out_ready, .out_crystal_id, .energy_cal, .fast_cal, .slow_cal,
		.energy_ok, .fast_ok, .slow_ok, .out_time, .out_over_threshold,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	cal_scoreboard calib_sb;

	// Which terms of each crystal the stimulus has written so far. A hit on a
	// crystal in range is only sent once every term it will read is known.
	logic [3:0]  coef_seen [1:MAX_CRY];
	bit          calm;            // no idling on either side while set
	int          items_sent;      // requests that the block acts on
	int          settings_applied;
	int          stall_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Result side: collect and check at each edge, then decide whether the
	// receiver stalls in the coming cycle. Stalls come in short bursts.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_port
		cal_result_t got;
		if (out_valid === 1'b1 && out_ready === 1'b1) begin
			got.crystal   = out_crystal_id;
			got.energy    = energy_cal;
			got.fast      = fast_cal;
			got.slow      = slow_cal;
			got.energy_ok = energy_ok;
			got.fast_ok   = fast_ok;
			got.slow_ok   = slow_ok;
			got.stamp     = out_time;
			got.tot       = out_over_threshold;
			calib_sb.check_result(got);
		end
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (!calm && $urandom_range(99) < 2) begin
			out_ready  <= 1'b0;
			stall_left = $urandom_range(0, 5);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// The run ends as a failure if neither channel moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Nothing moved on either channel for %0d cycles", STALL_LIMIT);
		$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Request builders and random field values, biased toward the extremes.
	// ------------------------------------------------------------------------
	function automatic logic [15:0] rand_raw();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			4: return 16'($urandom_range(0, 15));
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'(int'($urandom_range(0, 131072)) - 65536);  // within +-1.0
			default: return $urandom();
		endcase
	endfunction

	// Mostly clean hits; otherwise a single flag or a random flag word.
	function automatic logic [15:0] rand_errors();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)
			return 16'h0000;
		if (pick < 85)
			return 16'(1 << $urandom_range(15));
		return 16'($urandom());
	endfunction

	// Fields a request does not use are still randomized.
	function automatic cal_request_t make_hit(logic [15:0] id, logic [15:0] e, logic [15:0] f,
			logic [15:0] s, logic [15:0] err);
		cal_request_t r;
		r.kind    = REQ_HIT;
		r.crystal = id;
		r.energy  = e;
		r.fast    = f;
		r.slow    = s;
		r.errors  = err;
		r.stamp   = {$urandom(), $urandom()};
		r.tot     = 16'($urandom());
		r.power   = 2'($urandom());
		r.coef    = $urandom();
		return r;
	endfunction

	function automatic cal_request_t make_coef(logic [15:0] id, logic [1:0] term,
			logic [31:0] value);
		cal_request_t r;
		r         = make_hit(id, 16'($urandom()), 16'($urandom()), 16'($urandom()),
			16'($urandom()));
		r.kind    = REQ_COEF;
		r.power   = term;
		r.coef    = value;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Request side. Every task is entered right after a rising edge. The
	// sender may idle before a new request; once valid is up it stays up with
	// the same payload until the request is taken.
	// ------------------------------------------------------------------------
	task automatic send_req(input cal_request_t r);
		if (!calm && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_type       <= r.kind;
		crystal_id     <= r.crystal;
		raw_energy     <= r.energy;
		raw_fast       <= r.fast;
		raw_slow       <= r.slow;
		error_bits     <= r.errors;
		hit_time       <= r.stamp;
		over_threshold <= r.tot;
		term_index     <= r.power;
		coef_value     <= r.coef;
		in_valid       <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		calib_sb.note_request(r);
		// Writes outside the coefficient RAM are ignored by the block and do
		// not count as traffic.
		if (r.kind == REQ_COEF && r.crystal >= 1 && r.crystal <= MAX_CRY)
			coef_seen[r.crystal][r.power] = 1'b1;
		if (r.kind == REQ_HIT || (r.crystal >= 1 && r.crystal <= MAX_CRY))
			items_sent++;
	endtask

	task automatic write_group(input int id);
		int t;
		for (t = 0; t < TERM_SLOTS; t++)
			send_req(make_coef(16'(id), 2'(t), rand_coef()));
	endtask

	task automatic write_group_fixed(input int id, input logic [31:0] c0, input logic [31:0] c1,
			input logic [31:0] c2, input logic [31:0] c3);
		send_req(make_coef(16'(id), 2'd0, c0));
		send_req(make_coef(16'(id), 2'd1, c1));
		send_req(make_coef(16'(id), 2'd2, c2));
		send_req(make_coef(16'(id), 2'd3, c3));
	endtask

	// Hold the sender until every hit has been answered, then give the
	// pipeline time to finish any trailing coefficient write.
	task automatic drain();
		in_valid <= 1'b0;
		while (calib_sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the
	// edge where the access completes.
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		calib_sb.set_config(idx, value);
		settings_applied++;
	endtask

	// One random step. Most traffic is well formed: coefficients of a crystal
	// are written as a group before it is hit. The rest is hits outside the
	// configured range, lone overwrites and writes that land nowhere.
	task automatic random_step(input int limit, input int terms);
		int pick, id, mask;
		pick = $urandom_range(99);
		mask = (1 << terms) - 1;
		if (pick < 50 && limit > 0) begin
			if ($urandom_range(9) == 0)
				id = $urandom_range(1, limit);
			else
				id = $urandom_range(1, (limit < 64) ? limit : 64);
			if ((int'(coef_seen[id]) & mask) != mask)
				write_group(id);
			send_req(make_hit(16'(id), rand_raw(), rand_raw(), rand_raw(), rand_errors()));
		end else if (pick < 62) begin
			case ($urandom_range(3))
				0:       id = 0;
				1:       id = 65535;
				default: id = $urandom_range(limit + 1, 65535);
			endcase
			send_req(make_hit(16'(id), rand_raw(), rand_raw(), rand_raw(), rand_errors()));
		end else if (pick < 80) begin
			write_group(($urandom_range(3) == 0) ? $urandom_range(1, MAX_CRY) :
				$urandom_range(1, 64));
		end else if (pick < 94) begin
			send_req(make_coef(16'($urandom_range(1, MAX_CRY)), 2'($urandom_range(3)),
				rand_coef()));
		end else begin
			id = ($urandom_range(1) == 0) ? 0 : $urandom_range(MAX_CRY + 1, 65535);
			send_req(make_coef(16'(id), 2'($urandom_range(3)), rand_coef()));
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin : main_flow
		int crystal_cfg [8];
		int term_cfg    [8];
		int ph, target, limit, terms, fails;

		crystal_cfg      = '{0, 4096, 8191, 16, 1, 4096, 200, 8191};
		term_cfg         = '{1, 1, 4, 0, 7, 2, 3, 5};
		calib_sb         = new();
		calm             = 1'b0;
		items_sent       = 0;
		settings_applied = 0;
		stall_left       = 0;
		foreach (coef_seen[i])
			coef_seen[i] = '0;

		// Reset is held from the start and released on a rising edge.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset settings no crystal is in range, so this hit comes
		// back with all channels invalid and nothing is read.
		send_req(make_hit(16'd1, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000));

		// Crystal 1 holds the largest positive coefficient in every term and
		// crystal 4096 (the last one) mostly the most negative, so that both
		// saturation limits are reached. Crystal 2 holds small values.
		write_group_fixed(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		write_group_fixed(4096, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		write_group_fixed(2, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000, 32'h0000_0001);

		// Writes to crystal 0 and beyond the last crystal must be dropped.
		send_req(make_coef(16'd0, 2'd0, 32'h1234_5678));
		send_req(make_coef(16'd4097, 2'd1, 32'h1234_5678));
		send_req(make_coef(16'hFFFF, 2'd3, 32'h1234_5678));

		drain();
		write_reg(REG_NUM_CRYSTALS, 32'd4096);
		write_reg(REG_NUM_TERMS, 32'd4);

		send_req(make_hit(16'd1, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000));
		send_req(make_hit(16'd4096, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000));
		// Raw values of zero still pick up the constant term.
		send_req(make_hit(16'd2, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		// Energy-only flag, shape-only flag, shared flag, flags in no mask.
		send_req(make_hit(16'd2, 16'h0001, 16'hFFFF, 16'h0001, 16'h0020));
		send_req(make_hit(16'd2, 16'h1234, 16'h8000, 16'h7FFF, 16'h0080));
		send_req(make_hit(16'd2, 16'h1234, 16'h1234, 16'h1234, 16'h0002));
		send_req(make_hit(16'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hE041));
		// Crystal ids just past the range, zero and the top of the field.
		send_req(make_hit(16'd4097, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000));
		send_req(make_hit(16'd0, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000));
		send_req(make_hit(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF));

		// Random phases, each under its own settings. Register values above
		// the supported range and a term count of zero are included; one
		// phase runs with no idling at all.
		for (ph = 0; ph < 8; ph++) begin
			drain();
			write_reg(REG_NUM_CRYSTALS, 32'(crystal_cfg[ph]));
			write_reg(REG_NUM_TERMS, 32'(term_cfg[ph]));
			limit  = (crystal_cfg[ph] > MAX_CRY) ? MAX_CRY : crystal_cfg[ph];
			terms  = (term_cfg[ph] == 0) ? 1 :
				((term_cfg[ph] > TERM_SLOTS) ? TERM_SLOTS : term_cfg[ph]);
			calm   = (ph == 3);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				random_step(limit, terms);
		end
		calm = 1'b0;

		drain();
		fails = calib_sb.failures + calib_sb.pending();
		$display("Checked %0d hits (%0d in range, %0d saturated values), %0d coef writes",
			calib_sb.hits_seen, calib_sb.in_range_hits, calib_sb.saturations,
			calib_sb.writes_seen);
		$display("Used %0d register settings; %0d failures", settings_applied, fails);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### sim.f
design/chpc_pkg.sv
design/chpc_coef_ram.sv
design/chpc_lane.sv
design/crystal_hit_poly_calibrator_top.sv
sim/crystal_hit_poly_calibrator_top_tb.sv
